[src/mssc_pkg.sv]
// ----------------------------------------------------------------------------
// mssc_pkg
// Types, codes and tempo tables shared by the servo sweep controller.
// ----------------------------------------------------------------------------
package mssc_pkg;

    localparam int NUM_TEMPOS = 39;
    localparam int TABLE_LEN  = 39;
    localparam int LAST_SLOT  = ((NUM_TEMPOS < TABLE_LEN) ? NUM_TEMPOS : TABLE_LEN) - 1;

    localparam int DUTY_W  = 15;
    localparam int STEP_W  = 9;
    localparam int TEMPO_W = 6;
    localparam int NPM_W   = 4;
    localparam int SIG_W   = 3;
    localparam int CFG_IDX_W = 2;

    localparam logic [DUTY_W-1:0]  MAX_DUTY_RESET = DUTY_W'(3000);
    localparam logic [DUTY_W-1:0]  MIN_DUTY_RESET = DUTY_W'(1000);
    localparam logic [STEP_W-1:0]  STEP_RESET     = STEP_W'(139);
    localparam logic [TEMPO_W-1:0] TEMPO_RESET    = TEMPO_W'(38);
    localparam logic [NPM_W-1:0]   NPM_RESET      = NPM_W'(2);

    localparam logic [CFG_IDX_W-1:0] REG_MAX_DUTY = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DUTY = CFG_IDX_W'(1);

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_CMD  = 1'b1;

    typedef enum logic [1:0] {
        MODE_OFF    = 2'd0,
        MODE_ACCENT = 2'd1,
        MODE_PLAIN  = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        BEEP_NONE = 2'd0,
        BEEP_LOW  = 2'd1,
        BEEP_HIGH = 2'd2
    } t_beep;

    typedef enum logic [SIG_W-1:0] {
        SIG_2_2 = 3'd0,
        SIG_3_4 = 3'd1,
        SIG_4_4 = 3'd2,
        SIG_6_8 = 3'd3,
        SIG_9_8 = 3'd4,
        SIG_6_4 = 3'd5
    } t_sig;

    localparam logic [7:0] CH_DIGIT_0 = 8'h30;
    localparam logic [7:0] CH_DIGIT_9 = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_C = 8'h63;
    localparam logic [7:0] CH_MODE_OFF    = 8'h2E;
    localparam logic [7:0] CH_MODE_PLAIN  = 8'h2C;
    localparam logic [7:0] CH_MODE_ACCENT = 8'h2F;
    localparam logic [7:0] CH_SIG_2_2 = 8'h40;
    localparam logic [7:0] CH_SIG_3_4 = 8'h23;
    localparam logic [7:0] CH_SIG_4_4 = 8'h24;
    localparam logic [7:0] CH_SIG_6_8 = 8'h25;
    localparam logic [7:0] CH_SIG_9_8 = 8'h5E;
    localparam logic [7:0] CH_SIG_6_4 = 8'h26;

    localparam logic [7:0] UPPER_BASE = 8'd10;
    localparam logic [7:0] LOWER_BASE = 8'd36;

    localparam logic [7:0] STEP_TABLE [TABLE_LEN] = '{
        8'd27,  8'd28,  8'd30,  8'd31,  8'd32,  8'd33,  8'd35,  8'd36,  8'd37,  8'd39,
        8'd40,  8'd42,  8'd44,  8'd46,  8'd48,  8'd51,  8'd53,  8'd56,  8'd59,  8'd61,
        8'd64,  8'd67,  8'd69,  8'd72,  8'd75,  8'd77,  8'd80,  8'd84,  8'd88,  8'd92,
        8'd96,  8'd101, 8'd107, 8'd112, 8'd117, 8'd123, 8'd128, 8'd133, 8'd139
    };

    localparam logic [7:0] BPM_TABLE [TABLE_LEN] = '{
        8'd40,  8'd42,  8'd44,  8'd46,  8'd48,  8'd50,  8'd52,  8'd54,  8'd56,  8'd58,
        8'd60,  8'd63,  8'd66,  8'd69,  8'd72,  8'd76,  8'd80,  8'd84,  8'd88,  8'd92,
        8'd96,  8'd100, 8'd104, 8'd108, 8'd112, 8'd116, 8'd120, 8'd126, 8'd132, 8'd138,
        8'd144, 8'd152, 8'd160, 8'd168, 8'd176, 8'd184, 8'd192, 8'd200, 8'd208
    };

    typedef struct packed {
        logic       operation;
        logic [7:0] cmd_byte;
    } t_in_item;

    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        logic [1:0]        beep;
        logic [7:0]        tempo_bpm;
        logic [1:0]        beep_mode;
        logic [SIG_W-1:0]  signature_index;
    } t_out_item;

    // clamp a tempo index onto the last table entry
    function automatic logic [TEMPO_W-1:0] table_slot(input logic [TEMPO_W-1:0] idx);
        if (int'(idx) > LAST_SLOT) begin
            return TEMPO_W'(LAST_SLOT);
        end
        return idx;
    endfunction

endpackage

[src/metronome_servo_sweep_controller.sv]
// ----------------------------------------------------------------------------
// metronome_servo_sweep_controller
// Servo duty sweep with reversal beats, beep accents and command decoding.
// ----------------------------------------------------------------------------
//  channel  | handshake                  | payload
//  ---------+----------------------------+----------------------------------
//  in       | i_in_valid / o_in_ready    | i_in  (operation, cmd_byte)
//  out      | o_out_valid / i_out_ready  | o_out (duty, beep, tempo_bpm, ...)
//  cfg      | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
//  One item per cycle while o_in_ready is high; each result is registered.
//  The state update, tempo lookup and bound compare finish in the accept cycle.
//  A two-entry output buffer (output register plus skid) keeps o_in_ready
//  high while one result waits; it drops only when both entries are full.
//  Synchronous reset restores the duty, step, tempo, mode and signature.
// ----------------------------------------------------------------------------
module metronome_servo_sweep_controller (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  mssc_pkg::t_in_item                 i_in,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output mssc_pkg::t_out_item                o_out,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [mssc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [mssc_pkg::DUTY_W-1:0]        i_cfg_data
);

    logic [mssc_pkg::DUTY_W-1:0]  r_max_duty;
    logic [mssc_pkg::DUTY_W-1:0]  r_min_duty;
    logic [mssc_pkg::DUTY_W-1:0]  r_duty, n_duty;
    logic signed [mssc_pkg::STEP_W-1:0] r_step, n_step;
    logic [mssc_pkg::TEMPO_W-1:0] r_tempo, n_tempo;
    mssc_pkg::t_mode              r_mode, n_mode;
    logic [mssc_pkg::NPM_W-1:0]   r_npm, n_npm;
    logic [mssc_pkg::NPM_W-1:0]   r_beat, n_beat;
    logic [mssc_pkg::SIG_W-1:0]   r_sig, n_sig;

    mssc_pkg::t_out_item r_out, r_skid, n_item;
    logic                r_out_valid, r_skid_valid;

    logic accept;
    logic cfg_we;

    assign o_in_ready  = !r_skid_valid;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign accept      = i_in_valid && o_in_ready;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    always_comb begin
        logic signed [mssc_pkg::DUTY_W+1:0] sum;
        logic                               reverse;
        logic [1:0]                         beep;
        logic [7:0]                         c;
        logic [7:0]                         tcode;
        logic                               tsel;
        logic [mssc_pkg::NPM_W-1:0]         last;
        logic [mssc_pkg::TEMPO_W-1:0]       slot;

        n_duty  = r_duty;
        n_step  = r_step;
        n_tempo = r_tempo;
        n_mode  = r_mode;
        n_npm   = r_npm;
        n_beat  = r_beat;
        n_sig   = r_sig;
        beep    = mssc_pkg::BEEP_NONE;
        c       = i_in.cmd_byte;
        tcode   = 8'd0;
        tsel    = 1'b0;
        last    = r_npm - mssc_pkg::NPM_W'(1);
        sum     = $signed({2'b00, r_duty}) + (mssc_pkg::DUTY_W+2)'(r_step);
        reverse = (sum > $signed({2'b00, r_max_duty})) ||
                  (sum < $signed({2'b00, r_min_duty}));

        if (i_in.operation == mssc_pkg::OP_TICK) begin
            if (reverse) begin
                n_step = -r_step;
                unique case (r_mode)
                    mssc_pkg::MODE_ACCENT: begin
                        if ((r_npm != '0) && (r_beat < last)) begin
                            beep   = mssc_pkg::BEEP_LOW;
                            n_beat = r_beat + mssc_pkg::NPM_W'(1);
                        end else begin
                            beep   = mssc_pkg::BEEP_HIGH;
                            n_beat = '0;
                        end
                    end
                    mssc_pkg::MODE_PLAIN: beep = mssc_pkg::BEEP_LOW;
                    default: beep = mssc_pkg::BEEP_NONE;
                endcase
            end
            if (sum < 0) begin
                n_duty = '0;
            end else if (sum > $signed({2'b00, {mssc_pkg::DUTY_W{1'b1}}})) begin
                n_duty = '1;
            end else begin
                n_duty = sum[mssc_pkg::DUTY_W-1:0];
            end
        end else begin
            priority if (c >= mssc_pkg::CH_DIGIT_0 && c <= mssc_pkg::CH_DIGIT_9) begin
                tcode = c - mssc_pkg::CH_DIGIT_0;
                tsel  = 1'b1;
            end else if (c >= mssc_pkg::CH_UPPER_A && c <= mssc_pkg::CH_UPPER_Z) begin
                tcode = c - mssc_pkg::CH_UPPER_A + mssc_pkg::UPPER_BASE;
                tsel  = 1'b1;
            end else if (c >= mssc_pkg::CH_LOWER_A && c <= mssc_pkg::CH_LOWER_C) begin
                tcode = c - mssc_pkg::CH_LOWER_A + mssc_pkg::LOWER_BASE;
                tsel  = 1'b1;
            end else if (c == mssc_pkg::CH_MODE_OFF) begin
                n_mode = mssc_pkg::MODE_OFF;
            end else if (c == mssc_pkg::CH_MODE_PLAIN) begin
                n_mode = mssc_pkg::MODE_PLAIN;
            end else if (c == mssc_pkg::CH_MODE_ACCENT) begin
                n_mode = mssc_pkg::MODE_ACCENT;
            end else if (c == mssc_pkg::CH_SIG_2_2) begin
                n_npm = mssc_pkg::NPM_W'(2);
                n_sig = mssc_pkg::SIG_2_2;
            end else if (c == mssc_pkg::CH_SIG_3_4) begin
                n_npm = mssc_pkg::NPM_W'(3);
                n_sig = mssc_pkg::SIG_3_4;
            end else if (c == mssc_pkg::CH_SIG_4_4) begin
                n_npm = mssc_pkg::NPM_W'(4);
                n_sig = mssc_pkg::SIG_4_4;
            end else if (c == mssc_pkg::CH_SIG_6_8) begin
                n_npm = mssc_pkg::NPM_W'(6);
                n_sig = mssc_pkg::SIG_6_8;
            end else if (c == mssc_pkg::CH_SIG_9_8) begin
                n_npm = mssc_pkg::NPM_W'(9);
                n_sig = mssc_pkg::SIG_9_8;
            end else if (c == mssc_pkg::CH_SIG_6_4) begin
                n_npm = mssc_pkg::NPM_W'(6);
                n_sig = mssc_pkg::SIG_6_4;
            end else begin
                tsel = 1'b0;
            end
            if (tsel && (int'(tcode) < mssc_pkg::NUM_TEMPOS)) begin
                n_tempo = tcode[mssc_pkg::TEMPO_W-1:0];
            end
            n_step = $signed({1'b0, mssc_pkg::STEP_TABLE[mssc_pkg::table_slot(n_tempo)]});
        end

        slot                   = mssc_pkg::table_slot(n_tempo);
        n_item.duty            = n_duty;
        n_item.beep            = beep;
        n_item.tempo_bpm       = mssc_pkg::BPM_TABLE[slot];
        n_item.beep_mode       = n_mode;
        n_item.signature_index = n_sig;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_duty <= mssc_pkg::MAX_DUTY_RESET;
            r_min_duty <= mssc_pkg::MIN_DUTY_RESET;
        end else if (cfg_we) begin
            if (i_cfg_index == mssc_pkg::REG_MAX_DUTY) begin
                r_max_duty <= i_cfg_data;
            end else if (i_cfg_index == mssc_pkg::REG_MIN_DUTY) begin
                r_min_duty <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_duty  <= mssc_pkg::MIN_DUTY_RESET;
            r_step  <= mssc_pkg::STEP_RESET;
            r_tempo <= mssc_pkg::TEMPO_RESET;
            r_mode  <= mssc_pkg::MODE_OFF;
            r_npm   <= mssc_pkg::NPM_RESET;
            r_beat  <= '0;
            r_sig   <= mssc_pkg::SIG_2_2;
        end else if (accept) begin
            r_duty  <= n_duty;
            r_step  <= n_step;
            r_tempo <= n_tempo;
            r_mode  <= n_mode;
            r_npm   <= n_npm;
            r_beat  <= n_beat;
            r_sig   <= n_sig;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (r_skid_valid) begin
                if (i_out_ready) begin
                    r_out        <= r_skid;
                    r_skid_valid <= 1'b0;
                end
            end else if (accept) begin
                if (!r_out_valid || i_out_ready) begin
                    r_out       <= n_item;
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid       <= n_item;
                    r_skid_valid <= 1'b1;
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule
